// ----- hw/rtl/ptp_pkg.sv -----
// ptp_pkg: shared types, constants and the byte classifier for the tag pair parser
// no dependencies; used by the interfaces and every rtl module of the block
`timescale 1ns / 1ps

package ptp_pkg;

    // default width of positions and lengths
    localparam int OFFSET_WIDTH_DEF = 16;
    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    // reset value of the max_tags register
    localparam logic [7:0] MAX_TAGS_RST = 8'd255;
    localparam logic [7:0] TAG_COUNT_MAX = 8'd255;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_TAG    = 3'd1,
        ST_UNEXP_END  = 3'd2,
        ST_NO_WS      = 3'd3,
        ST_NO_VALUE   = 3'd4,
        ST_NOT_CLOSED = 3'd5
    } status_t;

    // parse phases
    typedef enum logic [3:0] {
        PH_PRE     = 4'd0,
        PH_KEYWS   = 4'd1,
        PH_KEY     = 4'd2,
        PH_VALWS   = 4'd3,
        PH_VALUE   = 4'd4,
        PH_CLOSEWS = 4'd5,
        PH_AFTER   = 4'd6,
        PH_NL1     = 4'd7
    } phase_t;

    // classified byte, as it travels from front to back
    typedef struct packed {
        logic is_space;
        logic is_alnum;
        logic is_lbrack;
        logic is_rbrack;
        logic is_quote;
        logic is_nl;
        logic is_zero;
    } class_t;

    // sort one text byte into the classes the parser tests
    function automatic class_t classify(input logic [7:0] b);
        class_t c;
        c.is_space  = (b inside {[CH_TAB:CH_CR], CH_SPACE});
        c.is_alnum  = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
        c.is_lbrack = (b == CH_LBRACK);
        c.is_rbrack = (b == CH_RBRACK);
        c.is_quote  = (b == CH_QUOTE);
        c.is_nl     = (b == CH_LF);
        c.is_zero   = (b == CH_NUL);
        return c;
    endfunction

endpackage

// ----- hw/rtl/ptp_if.sv -----
// ptp_if: valid/ready channel interfaces for text bytes, tag results and max_tags writes
// depends on ptp_pkg for the default width
`timescale 1ns / 1ps

interface ptp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ptp_res_if #(
    parameter int OFFSET_WIDTH = ptp_pkg::OFFSET_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    tag_valid;
    logic [OFFSET_WIDTH-1:0] key_offset;
    logic [OFFSET_WIDTH-1:0] key_length;
    logic [OFFSET_WIDTH-1:0] value_offset;
    logic [OFFSET_WIDTH-1:0] value_length;
    logic [2:0]              status;
    logic                    final_res;
    logic [7:0]              tags_read;

    modport source (output valid, output tag_valid, output key_offset, output key_length,
                    output value_offset, output value_length, output status,
                    output final_res, output tags_read, input ready);
    modport sink   (input valid, input tag_valid, input key_offset, input key_length,
                    input value_offset, input value_length, input status,
                    input final_res, input tags_read, output ready);
endinterface

interface ptp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_tags;

    modport source (output valid, output max_tags, input ready);
    modport sink   (input valid, input max_tags, output ready);
endinterface

// ----- hw/rtl/ptp_front.sv -----
// ptp_front: takes text byte requests and classifies each byte for the back end
// depends on ptp_pkg (class_t, classify) and ptp_byte_if
`timescale 1ns / 1ps

module ptp_front (
    ptp_byte_if.sink         text_in,
    input  logic             q_full,
    output logic             q_push,
    output ptp_pkg::class_t  q_item
);

    // accept whenever the queue has room
    assign text_in.ready = !q_full;
    assign q_push        = text_in.valid && !q_full;

    // character classes
    assign q_item = ptp_pkg::classify(text_in.text_byte);

endmodule

// ----- hw/rtl/ptp_queue.sv -----
// ptp_queue: short fifo of classified bytes between front and back
// depends on ptp_pkg (class_t, QUEUE_DEPTH)
`timescale 1ns / 1ps

module ptp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ptp_pkg::class_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output ptp_pkg::class_t  pop_item
);

    localparam int PTR_W = (ptp_pkg::QUEUE_DEPTH > 1) ? $clog2(ptp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptp_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ptp_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(ptp_pkg::QUEUE_DEPTH - 1);

    ptp_pkg::class_t        mem_reg [ptp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/ptp_back.sv -----
// ptp_back: tag pair state machine, position counters and registered result request
// depends on ptp_pkg (phase_t, status_t, class_t) and ptp_res_if
`timescale 1ns / 1ps

module ptp_back #(
    parameter int OFFSET_WIDTH = ptp_pkg::OFFSET_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       max_tags,
    input  logic             q_not_empty,
    input  ptp_pkg::class_t  q_item,
    output logic             q_pop,
    ptp_res_if.source        tag_out
);

    ptp_pkg::phase_t          phase_reg, phase_next, work_phase;
    logic [OFFSET_WIDTH-1:0]  pos_reg, pos_inc;
    logic [OFFSET_WIDTH-1:0]  key_start_reg, key_count_reg, key_count_inc;
    logic [OFFSET_WIDTH-1:0]  val_start_reg, val_count_reg, val_count_inc;
    logic [7:0]               tag_count_reg, tag_count_next;
    logic                     stopped_reg;

    logic                     res_valid_reg;
    logic                     res_tag_reg;
    logic [OFFSET_WIDTH-1:0]  res_koff_reg, res_klen_reg, res_voff_reg, res_vlen_reg;
    ptp_pkg::status_t         res_status_reg;
    logic                     res_fin_reg;
    logic [7:0]               res_tags_reg;

    logic                     take, active, over, nl_stop, after_nl;
    logic                     emit, emit_tag, fin;
    ptp_pkg::status_t         status;
    logic                     key_load, key_inc, val_load, val_inc;

    // an item moves on when the result slot is free or being emptied
    assign q_pop  = q_not_empty && (!res_valid_reg || tag_out.ready);
    assign take   = q_pop;
    assign active = take && !stopped_reg;

    // saturating increments
    assign pos_inc       = (&pos_reg)       ? pos_reg       : pos_reg + OFFSET_WIDTH'(1);
    assign key_count_inc = (&key_count_reg) ? key_count_reg : key_count_reg + OFFSET_WIDTH'(1);
    assign val_count_inc = (&val_count_reg) ? val_count_reg : val_count_reg + OFFSET_WIDTH'(1);

    // stop conditions and the phase that handles the byte
    assign over     = (tag_count_reg >= max_tags);
    assign nl_stop  = (phase_reg == ptp_pkg::PH_NL1)   && q_item.is_nl;
    assign after_nl = (phase_reg == ptp_pkg::PH_AFTER) && q_item.is_nl;
    assign work_phase = (phase_reg == ptp_pkg::PH_AFTER || phase_reg == ptp_pkg::PH_NL1)
                        ? ptp_pkg::PH_PRE : phase_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active && !over && !nl_stop)
        begin
            if (after_nl)
            begin
                phase_next = ptp_pkg::PH_NL1;
            end
            else
            begin
                phase_next = work_phase;
                case (work_phase)
                    ptp_pkg::PH_PRE:
                    begin
                        if (q_item.is_lbrack)
                            phase_next = ptp_pkg::PH_KEYWS;
                    end
                    ptp_pkg::PH_KEYWS:
                    begin
                        if (!q_item.is_space && q_item.is_alnum)
                            phase_next = ptp_pkg::PH_KEY;
                    end
                    ptp_pkg::PH_KEY:
                    begin
                        if (!q_item.is_alnum && q_item.is_space)
                            phase_next = ptp_pkg::PH_VALWS;
                    end
                    ptp_pkg::PH_VALWS:
                    begin
                        if (q_item.is_quote)
                            phase_next = ptp_pkg::PH_VALUE;
                    end
                    ptp_pkg::PH_VALUE:
                    begin
                        if (q_item.is_quote)
                            phase_next = ptp_pkg::PH_CLOSEWS;
                    end
                    ptp_pkg::PH_CLOSEWS:
                    begin
                        if (q_item.is_rbrack)
                            phase_next = ptp_pkg::PH_AFTER;
                    end
                    default:
                    begin
                        phase_next = ptp_pkg::PH_PRE;
                    end
                endcase
            end
        end
    end

    // result and datapath controls
    always_comb
    begin
        emit     = 1'b0;
        emit_tag = 1'b0;
        fin      = 1'b0;
        status   = ptp_pkg::ST_OK;
        key_load = 1'b0;
        key_inc  = 1'b0;
        val_load = 1'b0;
        val_inc  = 1'b0;
        tag_count_next = tag_count_reg;
        if (active)
        begin
            if (over || nl_stop)
            begin
                emit = 1'b1;
                fin  = 1'b1;
            end
            else if (!after_nl)
            begin
                case (work_phase)
                    ptp_pkg::PH_PRE:
                    begin
                        if (!q_item.is_space && !q_item.is_lbrack)
                        begin
                            emit   = 1'b1;
                            fin    = 1'b1;
                            status = ptp_pkg::ST_NOT_TAG;
                        end
                    end
                    ptp_pkg::PH_KEYWS:
                    begin
                        if (!q_item.is_space)
                        begin
                            if (q_item.is_alnum)
                            begin
                                key_load = 1'b1;
                            end
                            else
                            begin
                                emit   = 1'b1;
                                fin    = 1'b1;
                                status = ptp_pkg::ST_UNEXP_END;
                            end
                        end
                    end
                    ptp_pkg::PH_KEY:
                    begin
                        if (q_item.is_alnum)
                        begin
                            key_inc = 1'b1;
                        end
                        else if (!q_item.is_space)
                        begin
                            emit   = 1'b1;
                            fin    = 1'b1;
                            status = q_item.is_zero ? ptp_pkg::ST_UNEXP_END
                                                    : ptp_pkg::ST_NO_WS;
                        end
                    end
                    ptp_pkg::PH_VALWS:
                    begin
                        if (!q_item.is_space)
                        begin
                            if (q_item.is_quote)
                            begin
                                val_load = 1'b1;
                            end
                            else
                            begin
                                emit   = 1'b1;
                                fin    = 1'b1;
                                status = ptp_pkg::ST_NO_VALUE;
                            end
                        end
                    end
                    ptp_pkg::PH_VALUE:
                    begin
                        if (!q_item.is_quote)
                        begin
                            if (q_item.is_zero)
                            begin
                                emit   = 1'b1;
                                fin    = 1'b1;
                                status = ptp_pkg::ST_UNEXP_END;
                            end
                            else
                            begin
                                val_inc = 1'b1;
                            end
                        end
                    end
                    ptp_pkg::PH_CLOSEWS:
                    begin
                        if (q_item.is_rbrack)
                        begin
                            // closed tag, counted and checked against the limit
                            tag_count_next = (tag_count_reg == ptp_pkg::TAG_COUNT_MAX)
                                             ? tag_count_reg : tag_count_reg + 8'd1;
                            emit     = 1'b1;
                            emit_tag = 1'b1;
                            fin      = (tag_count_next >= max_tags);
                        end
                        else if (!q_item.is_space)
                        begin
                            emit   = 1'b1;
                            fin    = 1'b1;
                            status = ptp_pkg::ST_NOT_CLOSED;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ptp_pkg::PH_PRE;
            pos_reg       <= '0;
            key_start_reg <= '0;
            key_count_reg <= '0;
            val_start_reg <= '0;
            val_count_reg <= '0;
            tag_count_reg <= '0;
            stopped_reg   <= 1'b0;
        end
        else if (active)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_inc;
            tag_count_reg <= tag_count_next;
            if (fin)
                stopped_reg <= 1'b1;
            if (key_load)
            begin
                key_start_reg <= pos_reg;
                key_count_reg <= OFFSET_WIDTH'(1);
            end
            else if (key_inc)
            begin
                key_count_reg <= key_count_inc;
            end
            if (val_load)
            begin
                val_start_reg <= pos_inc;
                val_count_reg <= '0;
            end
            else if (val_inc)
            begin
                val_count_reg <= val_count_inc;
            end
        end
    end

    // result request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (active && emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (tag_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (active && emit)
        begin
            res_tag_reg    <= emit_tag;
            res_koff_reg   <= emit_tag ? key_start_reg : '0;
            res_klen_reg   <= emit_tag ? key_count_reg : '0;
            res_voff_reg   <= emit_tag ? val_start_reg : '0;
            res_vlen_reg   <= emit_tag ? val_count_reg : '0;
            res_status_reg <= status;
            res_fin_reg    <= fin;
            res_tags_reg   <= tag_count_next;
        end
    end

    assign tag_out.valid        = res_valid_reg;
    assign tag_out.tag_valid    = res_tag_reg;
    assign tag_out.key_offset   = res_koff_reg;
    assign tag_out.key_length   = res_klen_reg;
    assign tag_out.value_offset = res_voff_reg;
    assign tag_out.value_length = res_vlen_reg;
    assign tag_out.status       = res_status_reg;
    assign tag_out.final_res    = res_fin_reg;
    assign tag_out.tags_read    = res_tags_reg;

endmodule

// ----- hw/rtl/pgn_tag_pair_parser_core.sv -----
// Tag pair parser: takes one text byte a cycle on text_in while tag_out is not held (a zero
// byte ends the text) and gives one request on tag_out for each closed [Key "value"] tag,
// and a final request on the first error, on a blank line after a tag, or when max_tags
// tags are read; later bytes are taken and dropped until reset. Sustained rate is one byte
// per cycle while results are taken, set by the phase update in the back end; a byte passes
// through the two entry queue and its result then waits in the output register until it is
// taken. max_tags is written on cfg, by the user only while no byte is in flight; the
// block does not enforce this. Positions and lengths saturate at 2^OFFSET_WIDTH-1.
// depends on ptp_pkg, ptp_if, ptp_front, ptp_queue and ptp_back
`timescale 1ns / 1ps

module pgn_tag_pair_parser_core #(
    parameter int OFFSET_WIDTH = ptp_pkg::OFFSET_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ptp_byte_if.sink   text_in,
    ptp_res_if.source  tag_out,
    ptp_cfg_if.sink    cfg
);

    logic             q_full, q_push, q_pop, q_not_empty;
    ptp_pkg::class_t  q_in_item, q_out_item;
    logic [7:0]       max_tags_reg;

    // max_tags register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tags_reg <= ptp_pkg::MAX_TAGS_RST;
        end
        else if (cfg.valid)
        begin
            max_tags_reg <= cfg.max_tags;
        end
    end

    // byte intake and classification
    ptp_front u_front (
        .text_in (text_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    // decoupling queue
    ptp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out_item)
    );

    // parser and result register
    ptp_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_tags    (max_tags_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .tag_out     (tag_out)
    );

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for the tag pair parser, with its own parse predictor
// depends on ptp_pkg, ptp_if and pgn_tag_pair_parser_core
`timescale 1ns / 1ps

module testbench;

    localparam int OW = ptp_pkg::OFFSET_WIDTH_DEF;
    // cycles with no transfer on any channel before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic              tag_valid;
        logic [OW-1:0]     key_offset;
        logic [OW-1:0]     key_length;
        logic [OW-1:0]     value_offset;
        logic [OW-1:0]     value_length;
        ptp_pkg::status_t  status;
        logic              final_res;
        logic [7:0]        tags_read;
    } tag_result_t;

    // how the parse is brought to its stop at the end of the run
    typedef enum int {
        END_BLANK_LINE,
        END_TAG_LIMIT,
        END_LIMIT_LOWERED,
        END_NOT_TAG,
        END_EMPTY_KEY,
        END_KEY_CUT,
        END_NO_SPACE,
        END_NO_VALUE,
        END_VALUE_CUT,
        END_NOT_CLOSED
    } stop_case_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptp_byte_if text_if ();
    ptp_res_if #(.OFFSET_WIDTH(OW)) res_if ();
    ptp_cfg_if cfg_if ();

    pgn_tag_pair_parser_core #(.OFFSET_WIDTH(OW)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_if),
        .tag_out (res_if),
        .cfg     (cfg_if)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // bench-side drivers of the channels
    logic       byte_valid = 1'b0;
    logic [7:0] byte_data = 8'h00;
    logic       res_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    assign text_if.valid     = byte_valid;
    assign text_if.text_byte = byte_data;
    assign res_if.ready      = res_ready;
    assign cfg_if.valid      = cfg_valid;
    assign cfg_if.max_tags   = cfg_data;

    string alnum_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    // parse predictor state, at its reset values
    ptp_pkg::phase_t parse_at = ptp_pkg::PH_PRE;
    logic [OW-1:0]   pos_ctr = '0;
    logic [OW-1:0]   key_at = '0;
    logic [OW-1:0]   key_len = '0;
    logic [OW-1:0]   val_at = '0;
    logic [OW-1:0]   val_len = '0;
    logic [7:0]      tags_done = '0;
    logic            halted = 1'b0;
    logic [7:0]      tag_limit = ptp_pkg::MAX_TAGS_RST;

    tag_result_t due_results[$];
    logic [7:0]  text_queue[$];

    int  errors = 0;
    int  results_seen = 0;
    int  tags_checked = 0;
    int  byte_total = 0;
    int  cfg_writes = 0;
    int  idle_cycles = 0;
    int  hold_asked = 0;
    int  hold_given = 0;
    int  hold_left = 0;
    int  rx_mode = 0;
    int  rx_span = 0;
    int  gap_left = 0;
    int  burst_left = 0;
    logic byte_taken = 1'b0;
    logic moved;

    function automatic logic is_blank(input logic [7:0] b);
        return (b >= ptp_pkg::CH_TAB && b <= ptp_pkg::CH_CR) || b == ptp_pkg::CH_SPACE;
    endfunction

    function automatic logic is_word_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
    endfunction

    function automatic logic [OW-1:0] bump(input logic [OW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // parse stops with no tag attached
    task automatic stop_with(input ptp_pkg::status_t st);
        tag_result_t r;
        r = '0;
        r.status = st;
        r.final_res = 1'b1;
        r.tags_read = tags_done;
        halted = 1'b1;
        due_results.push_back(r);
    endtask

    // advance the predictor by one accepted text byte
    task automatic parse_byte(input logic [7:0] b);
        logic [OW-1:0] at;
        tag_result_t   r;
        if (halted)
            return;
        at = pos_ctr;
        pos_ctr = bump(pos_ctr);
        if (tags_done >= tag_limit)
        begin
            stop_with(ptp_pkg::ST_OK);
            return;
        end
        // a blank line straight after a tag ends the parse
        if (parse_at == ptp_pkg::PH_AFTER)
        begin
            if (b == ptp_pkg::CH_LF)
            begin
                parse_at = ptp_pkg::PH_NL1;
                return;
            end
            parse_at = ptp_pkg::PH_PRE;
        end
        else if (parse_at == ptp_pkg::PH_NL1)
        begin
            if (b == ptp_pkg::CH_LF)
            begin
                stop_with(ptp_pkg::ST_OK);
                return;
            end
            parse_at = ptp_pkg::PH_PRE;
        end
        case (parse_at)
            ptp_pkg::PH_PRE:
            begin
                if (b == ptp_pkg::CH_LBRACK)
                    parse_at = ptp_pkg::PH_KEYWS;
                else if (!is_blank(b))
                    stop_with(ptp_pkg::ST_NOT_TAG);
            end
            ptp_pkg::PH_KEYWS:
            begin
                if (is_word_char(b))
                begin
                    key_at = at;
                    key_len = OW'(1);
                    parse_at = ptp_pkg::PH_KEY;
                end
                else if (!is_blank(b))
                    stop_with(ptp_pkg::ST_UNEXP_END);
            end
            ptp_pkg::PH_KEY:
            begin
                if (is_word_char(b))
                    key_len = bump(key_len);
                else if (is_blank(b))
                    parse_at = ptp_pkg::PH_VALWS;
                else
                    stop_with((b == ptp_pkg::CH_NUL) ? ptp_pkg::ST_UNEXP_END
                                                     : ptp_pkg::ST_NO_WS);
            end
            ptp_pkg::PH_VALWS:
            begin
                if (b == ptp_pkg::CH_QUOTE)
                begin
                    val_at = bump(at);
                    val_len = '0;
                    parse_at = ptp_pkg::PH_VALUE;
                end
                else if (!is_blank(b))
                    stop_with(ptp_pkg::ST_NO_VALUE);
            end
            ptp_pkg::PH_VALUE:
            begin
                if (b == ptp_pkg::CH_QUOTE)
                    parse_at = ptp_pkg::PH_CLOSEWS;
                else if (b == ptp_pkg::CH_NUL)
                    stop_with(ptp_pkg::ST_UNEXP_END);
                else
                    val_len = bump(val_len);
            end
            ptp_pkg::PH_CLOSEWS:
            begin
                if (b == ptp_pkg::CH_RBRACK)
                begin
                    if (tags_done != ptp_pkg::TAG_COUNT_MAX)
                        tags_done = tags_done + 1'b1;
                    halted = (tags_done >= tag_limit);
                    parse_at = ptp_pkg::PH_AFTER;
                    r.tag_valid = 1'b1;
                    r.key_offset = key_at;
                    r.key_length = key_len;
                    r.value_offset = val_at;
                    r.value_length = val_len;
                    r.status = ptp_pkg::ST_OK;
                    r.final_res = halted;
                    r.tags_read = tags_done;
                    due_results.push_back(r);
                end
                else if (!is_blank(b))
                    stop_with(ptp_pkg::ST_NOT_CLOSED);
            end
            default:
                parse_at = ptp_pkg::PH_PRE;
        endcase
    endtask

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (errors < 40)
            $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
        errors++;
    endtask

    task automatic cmp_field(input string what, input longint got, input longint want);
        if (got != want)
            note_mismatch(what, got, want);
    endtask

    // compare an accepted result request with the oldest expectation
    task automatic check_result();
        tag_result_t want;
        results_seen++;
        if (due_results.size() == 0)
        begin
            note_mismatch("result with nothing expected", res_if.status, 0);
            return;
        end
        want = due_results.pop_front();
        if (want.tag_valid)
            tags_checked++;
        cmp_field("tag_valid", res_if.tag_valid, want.tag_valid);
        cmp_field("key_offset", res_if.key_offset, want.key_offset);
        cmp_field("key_length", res_if.key_length, want.key_length);
        cmp_field("value_offset", res_if.value_offset, want.value_offset);
        cmp_field("value_length", res_if.value_length, want.value_length);
        cmp_field("status", res_if.status, want.status);
        cmp_field("final_res", res_if.final_res, want.final_res);
        cmp_field("tags_read", res_if.tags_read, want.tags_read);
    endtask

    // sample every channel at the rising edge; check, predict and watch for a hang
    always @(posedge clk)
    begin
        byte_taken = text_if.valid && text_if.ready;
        moved = byte_taken;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            check_result();
            moved = 1'b1;
        end
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            tag_limit = cfg_if.max_tags;
            moved = 1'b1;
        end
        if (byte_taken)
            parse_byte(text_if.text_byte);
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no request moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // text byte driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                byte_valid <= 1'b0;
            end
            else if (text_queue.size() != 0)
            begin
                byte_data <= text_queue.pop_front();
                byte_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // result receiver: stall pattern of its own, plus long hold-offs on demand
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (hold_given != hold_asked)
        begin
            hold_given++;
            hold_left = HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(10, 80);
            end
            rx_span--;
            case (rx_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= 1'($urandom_range(0, 1));
                2: res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b);
        text_queue.push_back(b);
        byte_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // whitespace run; never two line feeds in a row so a blank line is only made on purpose
    task automatic push_ws(input int lo, input int hi);
        int         n;
        int         r;
        logic [7:0] b;
        logic [7:0] prev;
        n = $urandom_range(lo, hi);
        prev = ptp_pkg::CH_NUL;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 5);
            b = (r == 5) ? ptp_pkg::CH_SPACE : 8'(ptp_pkg::CH_TAB + r);
            if (b == ptp_pkg::CH_LF && prev == ptp_pkg::CH_LF)
                b = ptp_pkg::CH_SPACE;
            push_byte(b);
            prev = b;
        end
    endtask

    task automatic open_tag(input int key_n);
        push_ws(0, 3);
        push_byte(ptp_pkg::CH_LBRACK);
        push_ws(0, 2);
        for (int i = 0; i < key_n; i++)
            push_byte(alnum_chars[$urandom_range(0, alnum_chars.len() - 1)]);
    endtask

    task automatic push_value(input int val_n);
        logic [7:0] b;
        for (int i = 0; i < val_n; i++)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == ptp_pkg::CH_QUOTE);
            push_byte(b);
        end
    endtask

    task automatic push_tag(input int key_n, input int val_n);
        open_tag(key_n);
        push_ws(1, 3);
        push_byte(ptp_pkg::CH_QUOTE);
        push_value(val_n);
        push_byte(ptp_pkg::CH_QUOTE);
        push_ws(0, 2);
        push_byte(ptp_pkg::CH_RBRACK);
    endtask

    // well-formed tags with random content until the byte budget or tag cap is used
    task automatic push_tags(input int budget, input int cap);
        int start;
        int made;
        int kn;
        int vn;
        start = byte_total;
        made = 0;
        while (byte_total - start < budget && made < cap)
        begin
            kn = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            vn = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 48) : $urandom_range(0, 10);
            push_tag(kn, vn);
            made++;
        end
    endtask

    // a byte that is neither whitespace nor the banned one, alphanumerics optional
    function automatic logic [7:0] stray_byte(input logic alnum_ok, input logic [7:0] banned);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_blank(b) || b == banned || (!alnum_ok && is_word_char(b)));
        return b;
    endfunction

    function automatic logic [7:0] zero_or(input logic [7:0] b);
        return ($urandom_range(0, 1) == 0) ? ptp_pkg::CH_NUL : b;
    endfunction

    task automatic write_limit(input logic [7:0] v);
        @(negedge clk);
        cfg_data = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // wait until every byte is in and every expected result is out, then let the pipe empty
    task automatic settle();
        @(posedge clk);
        while (text_queue.size() != 0 || text_if.valid || due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic int room_left();
        return int'(tag_limit) - int'(tags_done) - 1;
    endfunction

    initial
    begin
        stop_case_t end_case;
        int         lo;
        int         n;
        logic [7:0] lim;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: smallest tag, every whitespace kind, key range ends, odd value bytes
        write_limit(ptp_pkg::MAX_TAGS_RST);
        push_text("[a \"\"]");
        push_byte(ptp_pkg::CH_LF);
        push_byte(ptp_pkg::CH_TAB);
        push_byte(8'h0B);
        push_byte(8'h0C);
        push_byte(ptp_pkg::CH_CR);
        push_text(" [\tAZaz09 \n\"");
        push_byte(8'hFF);
        push_byte(8'h01);
        push_text("]\"\r]");
        settle();

        // random tags under a lowered limit
        write_limit(8'($urandom_range(150, 254)));
        push_tags(600, room_left());
        settle();

        // random tags while the receiver holds off for a long stretch
        lo = int'(tags_done) + 60;
        if (lo > 255)
            lo = 255;
        write_limit(8'($urandom_range(lo, 255)));
        hold_asked++;
        push_tags(600, room_left());
        settle();

        // one long key, one long value, then more random tags
        push_tag(40, 3);
        push_tag(2, 60);
        push_tags(100, room_left() - 2);
        settle();

        // bring the parse to a stop; the floor value is written first in every run
        end_case = stop_case_t'($urandom_range(0, int'(END_NOT_CLOSED)));
        write_limit(8'd1);
        if (end_case == END_TAG_LIMIT)
        begin
            lim = tags_done + 8'($urandom_range(1, 3));
            write_limit(lim);
        end
        else if (end_case != END_LIMIT_LOWERED)
            write_limit(ptp_pkg::MAX_TAGS_RST);
        case (end_case)
            END_BLANK_LINE:
            begin
                push_tag(3, 4);
                push_byte(ptp_pkg::CH_LF);
                push_byte(ptp_pkg::CH_LF);
            end
            END_TAG_LIMIT:
            begin
                n = int'(tag_limit) - int'(tags_done);
                repeat (n) push_tag($urandom_range(1, 6), $urandom_range(0, 8));
            end
            END_NOT_TAG:
            begin
                push_ws(0, 2);
                push_byte(zero_or(stray_byte(1'b1, ptp_pkg::CH_LBRACK)));
            end
            END_EMPTY_KEY:
            begin
                open_tag(0);
                push_byte(zero_or(stray_byte(1'b0, ptp_pkg::CH_NUL)));
            end
            END_KEY_CUT:
            begin
                open_tag($urandom_range(1, 5));
                push_byte(ptp_pkg::CH_NUL);
            end
            END_NO_SPACE:
            begin
                open_tag($urandom_range(1, 5));
                push_byte(stray_byte(1'b0, ptp_pkg::CH_NUL));
            end
            END_NO_VALUE:
            begin
                open_tag($urandom_range(1, 5));
                push_ws(1, 2);
                push_byte(zero_or(stray_byte(1'b1, ptp_pkg::CH_QUOTE)));
            end
            END_VALUE_CUT:
            begin
                open_tag($urandom_range(1, 5));
                push_ws(1, 2);
                push_byte(ptp_pkg::CH_QUOTE);
                push_value($urandom_range(0, 5));
                push_byte(ptp_pkg::CH_NUL);
            end
            END_NOT_CLOSED:
            begin
                open_tag($urandom_range(1, 5));
                push_ws(1, 2);
                push_byte(ptp_pkg::CH_QUOTE);
                push_value($urandom_range(0, 5));
                push_byte(ptp_pkg::CH_QUOTE);
                push_ws(0, 2);
                push_byte(zero_or(stray_byte(1'b1, ptp_pkg::CH_RBRACK)));
            end
            default:
                ;
        endcase
        // bytes after the stop must be swallowed without a result
        repeat (30) push_byte(8'($urandom_range(0, 255)));
        settle();

        $display("parsed %0d text bytes; %0d results checked, %0d of them tag pairs",
                 byte_total, results_seen, tags_checked);
        $display("%0d limit writes; parse ended by %s with %0d tags counted",
                 cfg_writes, end_case.name(), tags_done);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
